FILE: src/three_term_recurrence_checksum_unit_defines.svh
// Assertion macros for the checksum unit.
`ifndef THREE_TERM_RECURRENCE_CHECKSUM_UNIT_DEFINES_SVH
`define THREE_TERM_RECURRENCE_CHECKSUM_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define TTRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ttrc same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define TTRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ttrc next-cycle check failed");

`endif

FILE: src/ttrc_pkg.sv
package ttrc_pkg;

    localparam logic [7:0]  MUL_A        = 8'd17;
    localparam logic [7:0]  MUL_B        = 8'd31;
    localparam logic [7:0]  FIRST_OFFSET = 8'd7;
    localparam logic [15:0] TERM_MOD     = 16'hFFFF;
    // multiple of the modulus that lifts any negative difference to >= 0
    localparam logic [24:0] WRAP_BIAS    = 25'(65535 * 256);

    typedef struct packed {
        logic [15:0] prev_term;
        logic [15:0] cur_term;
        logic [7:0]  position;
        logic        at_start;
    } t_state;

    localparam t_state STATE_RESET = '{
        prev_term: 16'd1,
        cur_term:  16'd1,
        position:  8'd0,
        at_start:  1'b1
    };

endpackage

FILE: src/ttrc_if.sv
interface ttrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ttrc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

FILE: src/ttrc_step.sv
module ttrc_step
    import ttrc_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    output t_state     o_state
);

    logic [12:0] ma_full;
    logic [12:0] mb_full;
    logic [8:0]  coef_a;
    logic [24:0] prod_a;
    logic [23:0] prod_b;
    logic        neg;
    logic [24:0] diff;
    logic [16:0] fold;
    logic [15:0] next_term;

    always_comb begin
        ma_full = 13'(i_state.position) * 13'(MUL_A);
        mb_full = 13'(i_state.position) * 13'(MUL_B);
        coef_a  = 9'(i_data_byte) + 9'(ma_full[7:0]);
        prod_a  = 25'(coef_a) * 25'(i_state.cur_term);
        prod_b  = 24'(mb_full[7:0]) * 24'(i_state.prev_term);
        neg     = prod_a < 25'(prod_b);
        // 2^64 wraps to +1 modulo 65535
        if (neg) begin
            diff = prod_a + WRAP_BIAS + 25'd1 - 25'(prod_b);
        end else begin
            diff = prod_a - 25'(prod_b);
        end
        // end-around fold: 2^16 is 1 modulo 65535
        fold = 17'(diff[24:16]) + 17'(diff[15:0]);
        if (fold >= 17'(TERM_MOD)) begin
            next_term = 16'(fold - 17'(TERM_MOD));
        end else begin
            next_term = fold[15:0];
        end

        if (i_state.at_start) begin
            o_state.prev_term = 16'd1;
            o_state.cur_term  = 16'(i_data_byte) + 16'(FIRST_OFFSET);
            o_state.position  = 8'd1;
            o_state.at_start  = 1'b0;
        end else begin
            o_state.prev_term = i_state.cur_term;
            o_state.cur_term  = next_term;
            o_state.position  = i_state.position + 8'd1;
            o_state.at_start  = 1'b0;
        end
    end

endmodule

FILE: src/three_term_recurrence_checksum_unit.sv
// Byte-stream checksum by a three-term recurrence. One byte item is taken per
// cycle unless stalled; the checksum item appears on the output in the cycle
// after the byte marked last is taken, and the recurrence state is then back at
// its reset values so the next message can start on the next cycle. The rate
// of one byte per cycle is set by the feedback of the current term through
// the two multiplies and the modulo-65535 fold into the state registers. The
// checksum sits in an output register; while it is held and the sink is not
// ready, the input is stalled, and a checksum taken frees the input that cycle.
`include "three_term_recurrence_checksum_unit_defines.svh"

module three_term_recurrence_checksum_unit
    import ttrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttrc_in_if.sink     i_in,
    ttrc_out_if.source  o_out
);

    t_state      r_state;
    t_state      n_state;
    t_state      step_state;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [15:0] r_checksum;
    logic        in_acc;
    logic        last_acc;
    logic        out_stall;
    logic        state_idle;

    ttrc_step u_step (
        .i_state     (r_state),
        .i_data_byte (i_in.data_byte),
        .o_state     (step_state)
    );

    assign out_stall  = r_out_valid && !o_out.ready;
    assign i_in.ready = !out_stall;
    assign in_acc     = i_in.valid && i_in.ready;
    assign last_acc   = in_acc && i_in.last_byte;
    assign state_idle = (r_state == STATE_RESET);

    always_comb begin
        n_state     = r_state;
        n_out_valid = out_stall;
        if (in_acc) begin
            if (i_in.last_byte) begin
                n_state     = STATE_RESET;
                n_out_valid = 1'b1;
            end else begin
                n_state = step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_acc) begin
            r_checksum <= step_state.cur_term;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.checksum = r_checksum;

    `TTRC_ASSERT_NOW(a_hold_stalls_input, i_clk, i_rst_n, out_stall, !i_in.ready)
    `TTRC_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, last_acc, r_out_valid && state_idle)
    `TTRC_ASSERT_NOW(a_sum_in_range, i_clk, i_rst_n, r_out_valid, r_checksum != TERM_MOD)
    `TTRC_ASSERT_NOW(a_start_at_zero, i_clk, i_rst_n, r_state.at_start, r_state.position == 8'd0)

endmodule
